FILE: design/frame_pacing_statistics_core_defines.svh
// assertion macros shared by the frame pacing statistics files
`ifndef FRAME_PACING_STATISTICS_CORE_DEFINES_SVH
`define FRAME_PACING_STATISTICS_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/fps_pkg.sv
// types, codes and microcode program of the frame pacing statistics block
`timescale 1ns / 1ps

package fps_pkg;

  // fixed field widths and constants
  localparam int PERIOD_W = 10;
  localparam int FPS_W    = 18;
  localparam logic [PERIOD_W-1:0] MS_PER_S = 10'd1000;
  localparam logic [FPS_W-1:0]    RATE_NUM = 18'd256000;

  // register indexes
  localparam logic REG_FRAME_RATE = 1'b0;
  localparam logic REG_MEASURE    = 1'b1;

  // input actions
  localparam logic [1:0] ACT_PACED   = 2'd0;
  localparam logic [1:0] ACT_MEASURE = 2'd1;
  localparam logic [1:0] ACT_REFRESH = 2'd2;

  // program steps
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t ST_SWP_INIT = 4'd0;
  localparam step_t ST_SWP_READ = 4'd1;
  localparam step_t ST_SWP_LOOP = 4'd2;
  localparam step_t ST_SWP_DONE = 4'd3;
  localparam step_t ST_FETCH    = 4'd4;
  localparam step_t ST_DECODE   = 4'd5;
  localparam step_t ST_RECORD   = 4'd6;
  localparam step_t ST_START_AF = 4'd7;
  localparam step_t ST_GET_AF   = 4'd8;
  localparam step_t ST_GET_AW   = 4'd9;
  localparam step_t ST_GET_RF   = 4'd10;
  localparam step_t ST_GET_RW   = 4'd11;
  localparam step_t ST_INDEX    = 4'd12;
  localparam step_t ST_EMIT     = 4'd13;

  // hold conditions
  typedef logic [1:0] hold_t;
  localparam hold_t W_NONE = 2'd0;
  localparam hold_t W_IN   = 2'd1;
  localparam hold_t W_DIV  = 2'd2;
  localparam hold_t W_OUT  = 2'd3;

  // jump conditions
  typedef logic [2:0] jump_t;
  localparam jump_t J_NEXT       = 3'd0;
  localparam jump_t J_ALWAYS     = 3'd1;
  localparam jump_t J_NO_REC     = 3'd2;
  localparam jump_t J_NOT_LAST   = 3'd3;
  localparam jump_t J_SWEEP_MORE = 3'd4;

  // datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE     = 4'd0;
  localparam op_t OP_SWP_INIT = 4'd1;
  localparam op_t OP_SWP_ACC  = 4'd2;
  localparam op_t OP_SWP_END  = 4'd3;
  localparam op_t OP_TAKE     = 4'd4;
  localparam op_t OP_DECODE   = 4'd5;
  localparam op_t OP_RECORD   = 4'd6;
  localparam op_t OP_LATCH_MM = 4'd7;
  localparam op_t OP_INDEX    = 4'd8;
  localparam op_t OP_EMIT     = 4'd9;

  // ram read address select
  typedef logic [1:0] rd_t;
  localparam rd_t RD_IDX     = 2'd0;
  localparam rd_t RD_PTR     = 2'd1;
  localparam rd_t RD_PTR_INC = 2'd2;

  // divider operand select
  typedef logic [2:0] dsel_t;
  localparam dsel_t DV_NONE   = 3'd0;
  localparam dsel_t DV_PERIOD = 3'd1;
  localparam dsel_t DV_AF     = 3'd2;
  localparam dsel_t DV_AW     = 3'd3;
  localparam dsel_t DV_RF     = 3'd4;
  localparam dsel_t DV_RW     = 3'd5;

  // quotient capture select
  typedef logic [2:0] cap_t;
  localparam cap_t CP_NONE   = 3'd0;
  localparam cap_t CP_PERIOD = 3'd1;
  localparam cap_t CP_AF     = 3'd2;
  localparam cap_t CP_AW     = 3'd3;
  localparam cap_t CP_RF     = 3'd4;
  localparam cap_t CP_RW     = 3'd5;

  typedef struct packed {
    hold_t hold_sel;
    jump_t jump_sel;
    step_t target;
    op_t   op;
    rd_t   rd_sel;
    dsel_t div_sel;
    cap_t  cap_sel;
  } ucode_t;

  typedef struct packed {
    op_t   op;
    rd_t   rd_sel;
    dsel_t div_sel;
    cap_t  cap_sel;
  } dp_ctrl_t;

  typedef struct packed {
    logic rec;
    logic last;
    logic sweep_last;
    logic out_stall;
    logic div_done;
  } dp_stat_t;

  // microcode rom, all-zero fields mean no action
  function automatic ucode_t fps_ucode(input step_t step);
    ucode_t u;
    u = '0;
    case (step)
      ST_SWP_INIT: begin
        u.op      = OP_SWP_INIT;
        u.div_sel = DV_PERIOD;
      end
      ST_SWP_READ: begin
        u.rd_sel = RD_PTR;
      end
      ST_SWP_LOOP: begin
        u.op       = OP_SWP_ACC;
        u.rd_sel   = RD_PTR_INC;
        u.jump_sel = J_SWEEP_MORE;
        u.target   = ST_SWP_LOOP;
      end
      ST_SWP_DONE: begin
        u.hold_sel = W_DIV;
        u.op       = OP_SWP_END;
        u.cap_sel  = CP_PERIOD;
      end
      ST_FETCH: begin
        u.hold_sel = W_IN;
        u.op       = OP_TAKE;
      end
      ST_DECODE: begin
        u.op       = OP_DECODE;
        u.rd_sel   = RD_IDX;
        u.jump_sel = J_NO_REC;
        u.target   = ST_INDEX;
      end
      ST_RECORD: begin
        u.op       = OP_RECORD;
        u.jump_sel = J_NOT_LAST;
        u.target   = ST_INDEX;
      end
      ST_START_AF: begin
        u.div_sel = DV_AF;
      end
      ST_GET_AF: begin
        u.hold_sel = W_DIV;
        u.cap_sel  = CP_AF;
        u.div_sel  = DV_AW;
      end
      ST_GET_AW: begin
        u.hold_sel = W_DIV;
        u.cap_sel  = CP_AW;
        u.div_sel  = DV_RF;
      end
      ST_GET_RF: begin
        u.hold_sel = W_DIV;
        u.cap_sel  = CP_RF;
        u.div_sel  = DV_RW;
      end
      ST_GET_RW: begin
        u.hold_sel = W_DIV;
        u.cap_sel  = CP_RW;
        u.op       = OP_LATCH_MM;
      end
      ST_INDEX: begin
        u.op = OP_INDEX;
      end
      ST_EMIT: begin
        u.hold_sel = W_OUT;
        u.op       = OP_EMIT;
        u.jump_sel = J_ALWAYS;
        u.target   = ST_FETCH;
      end
      default: begin
        u.jump_sel = J_ALWAYS;
        u.target   = ST_SWP_INIT;
      end
    endcase
    return u;
  endfunction

endpackage

FILE: design/fps_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module fps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/fps_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module fps_div #(
  parameter int DIV_W = 24,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DIV_W-1:0] quot,
  output logic             done
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DVS_W:0]   rem;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_next;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             qbit;

  // quot shifts the dividend out at the top and the quotient in at the bottom
  always_comb begin
    rem_sh = {rem[DVS_W-1:0], quot[DIV_W-1]};
    qbit   = (rem_sh >= {1'b0, dvs});
    rem_next = qbit ? (rem_sh - {1'b0, dvs}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[DIV_W-2:0], qbit};
      rem  <= rem_next;
    end
  end

endmodule

FILE: design/fps_dp.sv
// datapath: window store, running totals, min/max, divider and result register
`timescale 1ns / 1ps
`include "frame_pacing_statistics_core_defines.svh"

module fps_dp #(
  parameter int MAX_WINDOW = 256,
  parameter int TIME_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fps_pkg::dp_ctrl_t               ctrl,
  output fps_pkg::dp_stat_t               stat,
  input  logic                            rate_wr,
  input  logic [$clog2(MAX_WINDOW+1)-1:0] rate_new,
  input  logic [$clog2(MAX_WINDOW+1)-1:0] rate,
  input  logic                            measure_en,
  input  logic [1:0]                      action,
  input  logic [15:0]                     work_ms,
  input  logic [15:0]                     frame_ms,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [9:0]                      sleep_ms,
  output logic                            window_done,
  output logic [15:0]                     avg_frame_ms,
  output logic [15:0]                     avg_work_ms,
  output logic [17:0]                     frame_fps_q8,
  output logic [17:0]                     work_fps_q8,
  output logic [15:0]                     min_frame_ms,
  output logic [15:0]                     max_frame_ms
);

  localparam int RATE_W = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W  = $clog2(MAX_WINDOW);
  localparam int TB     = TIME_BITS;
  localparam int TOT_W  = TIME_BITS + IDX_W;
  localparam int DIV_W  = (TOT_W > fps_pkg::FPS_W) ? TOT_W : fps_pkg::FPS_W;
  localparam int DVS_W  = (TIME_BITS > RATE_W) ? TIME_BITS : RATE_W;
  localparam int CW     = (TIME_BITS > fps_pkg::PERIOD_W) ? TIME_BITS : fps_pkg::PERIOD_W;

  logic [TB-1:0]    work_sat;
  logic [TB-1:0]    frame_sat;
  logic [1:0]       act_q;
  logic [TB-1:0]    work_q;
  logic [TB-1:0]    frame_q;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] ptr;
  logic [RATE_W-1:0] keep_limit;
  logic             in_sweep;
  logic [TOT_W-1:0] frame_total;
  logic [TOT_W-1:0] work_total;
  logic [TB-1:0]    run_min;
  logic [TB-1:0]    run_max;
  logic [fps_pkg::PERIOD_W-1:0] period;
  logic [9:0]       sleep_q;
  logic             win_done_q;
  logic [TB-1:0]    lat_avg_frame;
  logic [TB-1:0]    lat_avg_work;
  logic [fps_pkg::FPS_W-1:0] lat_fps_frame;
  logic [fps_pkg::FPS_W-1:0] lat_fps_work;
  logic [TB-1:0]    lat_min;
  logic [TB-1:0]    lat_max;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  logic [2*TB-1:0]  ram_wdata;
  logic [2*TB-1:0]  ram_rdata;
  logic [TB-1:0]    old_work;
  logic [TB-1:0]    old_frame;
  logic             keep_entry;

  logic             div_start;
  logic [DIV_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [DIV_W-1:0] div_quot;
  logic             div_done;

  logic [CW-1:0]    period_ext;
  logic [CW-1:0]    work_ext;

  // input times saturate to the internal time width
  if (TIME_BITS >= 16) begin : g_wide
    assign work_sat  = TB'(work_ms);
    assign frame_sat = TB'(frame_ms);
  end else begin : g_narrow
    assign work_sat  = (|work_ms[15:TIME_BITS])  ? '1 : work_ms[TIME_BITS-1:0];
    assign frame_sat = (|frame_ms[15:TIME_BITS]) ? '1 : frame_ms[TIME_BITS-1:0];
  end

  assign {old_work, old_frame} = ram_rdata;
  assign keep_entry = (RATE_W'(ptr) < keep_limit);
  assign period_ext = CW'(period);
  assign work_ext   = CW'(work_q);

  assign stat.rec = measure_en &&
                    (act_q == fps_pkg::ACT_PACED || act_q == fps_pkg::ACT_MEASURE);
  assign stat.last       = (idx == IDX_W'(rate - RATE_W'(1)));
  assign stat.sweep_last = (ptr == IDX_W'(MAX_WINDOW - 1));
  assign stat.out_stall  = out_valid && !out_ready;
  assign stat.div_done   = div_done;

  // ram port selection
  always_comb begin
    case (ctrl.rd_sel)
      fps_pkg::RD_PTR:     ram_raddr = ptr;
      fps_pkg::RD_PTR_INC: ram_raddr = ptr + IDX_W'(1);
      default:             ram_raddr = idx;
    endcase
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = '0;
    if (ctrl.op == fps_pkg::OP_RECORD) begin
      ram_we    = 1'b1;
      ram_waddr = idx;
      ram_wdata = {work_q, frame_q};
    end else if (ctrl.op == fps_pkg::OP_SWP_ACC) begin
      // entries beyond the window length are zeroed
      ram_we = !keep_entry;
    end
  end

  // divider operand selection
  always_comb begin
    div_start = 1'b1;
    div_dvd   = '0;
    div_dvs   = '0;
    case (ctrl.div_sel)
      fps_pkg::DV_PERIOD: begin
        div_dvd = DIV_W'(fps_pkg::MS_PER_S);
        div_dvs = DVS_W'(rate);
      end
      fps_pkg::DV_AF: begin
        div_dvd = DIV_W'(frame_total);
        div_dvs = DVS_W'(rate);
      end
      fps_pkg::DV_AW: begin
        div_dvd = DIV_W'(work_total);
        div_dvs = DVS_W'(rate);
      end
      fps_pkg::DV_RF: begin
        div_dvd = DIV_W'(fps_pkg::RATE_NUM);
        div_dvs = DVS_W'(lat_avg_frame);
      end
      fps_pkg::DV_RW: begin
        div_dvd = DIV_W'(fps_pkg::RATE_NUM);
        div_dvs = DVS_W'(lat_avg_work);
      end
      default: div_start = 1'b0;
    endcase
  end

  fps_ram #(
    .WIDTH(2 * TB),
    .DEPTH(MAX_WINDOW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  fps_div #(
    .DIV_W(DIV_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .quot    (div_quot),
    .done    (div_done)
  );

  // control state and model state with a reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      idx           <= '0;
      in_sweep      <= 1'b1;
      keep_limit    <= '0;
      run_min       <= '1;
      run_max       <= '0;
      lat_avg_frame <= '0;
      lat_avg_work  <= '0;
      lat_fps_frame <= '0;
      lat_fps_work  <= '0;
      lat_min       <= '0;
      lat_max       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (ctrl.op == fps_pkg::OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (rate_wr) begin
        // a rewrite during a clearing pass keeps the shorter length
        keep_limit <= (in_sweep && keep_limit < rate_new) ? keep_limit : rate_new;
        in_sweep   <= 1'b1;
        idx        <= '0;
      end else begin
        case (ctrl.op)
          fps_pkg::OP_SWP_END: in_sweep <= 1'b0;
          fps_pkg::OP_RECORD: begin
            if (frame_q < run_min) run_min <= frame_q;
            if (frame_q > run_max) run_max <= frame_q;
          end
          fps_pkg::OP_LATCH_MM: begin
            lat_min <= run_min;
            lat_max <= run_max;
            run_min <= '1;
            run_max <= '0;
          end
          fps_pkg::OP_INDEX: begin
            if (act_q == fps_pkg::ACT_PACED || act_q == fps_pkg::ACT_MEASURE) begin
              idx <= stat.last ? '0 : idx + IDX_W'(1);
            end else if (act_q == fps_pkg::ACT_REFRESH) begin
              idx <= '0;
            end
          end
          default: ;
        endcase
        case (ctrl.cap_sel)
          fps_pkg::CP_AF: lat_avg_frame <= TB'(div_quot);
          fps_pkg::CP_AW: lat_avg_work  <= TB'(div_quot);
          fps_pkg::CP_RF: lat_fps_frame <= (lat_avg_frame == '0) ? '0
                                           : fps_pkg::FPS_W'(div_quot);
          fps_pkg::CP_RW: lat_fps_work  <= (lat_avg_work == '0) ? '0
                                           : fps_pkg::FPS_W'(div_quot);
          default: ;
        endcase
      end
    end
  end

  // working registers, always written before use
  always_ff @(posedge clk) begin
    case (ctrl.op)
      fps_pkg::OP_SWP_INIT: begin
        frame_total <= '0;
        work_total  <= '0;
        ptr         <= '0;
      end
      fps_pkg::OP_SWP_ACC: begin
        if (keep_entry) begin
          frame_total <= frame_total + TOT_W'(old_frame);
          work_total  <= work_total + TOT_W'(old_work);
        end
        ptr <= ptr + IDX_W'(1);
      end
      fps_pkg::OP_TAKE: begin
        act_q   <= action;
        work_q  <= work_sat;
        // a measure-only frame counts its work time as the frame time
        frame_q <= (action == fps_pkg::ACT_MEASURE) ? work_sat : frame_sat;
      end
      fps_pkg::OP_DECODE: begin
        win_done_q <= 1'b0;
        sleep_q    <= (act_q == fps_pkg::ACT_PACED && period_ext > work_ext)
                      ? 10'(period_ext - work_ext) : '0;
      end
      fps_pkg::OP_RECORD: begin
        frame_total <= frame_total + TOT_W'(frame_q) - TOT_W'(old_frame);
        work_total  <= work_total + TOT_W'(work_q) - TOT_W'(old_work);
      end
      fps_pkg::OP_LATCH_MM: win_done_q <= 1'b1;
      fps_pkg::OP_EMIT: begin
        sleep_ms     <= sleep_q;
        window_done  <= win_done_q;
        avg_frame_ms <= 16'(lat_avg_frame);
        avg_work_ms  <= 16'(lat_avg_work);
        frame_fps_q8 <= lat_fps_frame;
        work_fps_q8  <= lat_fps_work;
        min_frame_ms <= 16'(lat_min);
        max_frame_ms <= 16'(lat_max);
      end
      default: ;
    endcase
    if (ctrl.cap_sel == fps_pkg::CP_PERIOD) begin
      period <= fps_pkg::PERIOD_W'(div_quot);
    end
  end

  `FPS_ASSERT_NOW(a_no_take_in_sweep, clk, rst, ctrl.op == fps_pkg::OP_TAKE, !in_sweep,
    "item taken during clearing pass")
  `FPS_ASSERT_NOW(a_idx_in_window, clk, rst, 1'b1, RATE_W'(idx) < rate,
    "frame index outside window")
  `FPS_ASSERT_NEXT(a_minmax_restart, clk, rst, ctrl.op == fps_pkg::OP_LATCH_MM,
    run_min == '1 && run_max == '0, "running min/max not restarted after latch")

endmodule

FILE: design/fps_seq.sv
// microcode sequencer: step counter, rom fetch, hold and jump logic
`timescale 1ns / 1ps
`include "frame_pacing_statistics_core_defines.svh"

module fps_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic              in_valid,
  input  fps_pkg::dp_stat_t stat,
  output logic              in_ready,
  output fps_pkg::dp_ctrl_t ctrl
);

  fps_pkg::step_t  pc;
  fps_pkg::step_t  pc_next;
  fps_pkg::ucode_t uc;
  logic            hold;
  logic            take_jump;
  logic            fire;

  assign uc       = fps_pkg::fps_ucode(pc);
  assign in_ready = (pc == fps_pkg::ST_FETCH) && !restart;

  always_comb begin
    case (uc.hold_sel)
      fps_pkg::W_IN:  hold = !(in_valid && in_ready);
      fps_pkg::W_DIV: hold = !stat.div_done;
      fps_pkg::W_OUT: hold = stat.out_stall;
      default:        hold = 1'b0;
    endcase
    case (uc.jump_sel)
      fps_pkg::J_ALWAYS:     take_jump = 1'b1;
      fps_pkg::J_NO_REC:     take_jump = !stat.rec;
      fps_pkg::J_NOT_LAST:   take_jump = !stat.last;
      fps_pkg::J_SWEEP_MORE: take_jump = !stat.sweep_last;
      default:               take_jump = 1'b0;
    endcase
  end

  // a frame rate write cancels the current step
  assign fire = !hold && !restart;

  always_comb begin
    if (restart) begin
      pc_next = fps_pkg::ST_SWP_INIT;
    end else if (!fire) begin
      pc_next = pc;
    end else if (take_jump) begin
      pc_next = uc.target;
    end else begin
      pc_next = pc + fps_pkg::STEP_W'(1);
    end
    ctrl.op      = fire ? uc.op : fps_pkg::OP_NONE;
    ctrl.rd_sel  = uc.rd_sel;
    ctrl.div_sel = fire ? uc.div_sel : fps_pkg::DV_NONE;
    ctrl.cap_sel = fire ? uc.cap_sel : fps_pkg::CP_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= fps_pkg::ST_SWP_INIT;
    end else begin
      pc <= pc_next;
    end
  end

  `FPS_ASSERT_NEXT(a_restart_to_sweep, clk, rst, restart, pc == fps_pkg::ST_SWP_INIT,
    "frame rate write did not restart the clearing pass")

endmodule

FILE: design/frame_pacing_statistics_core.sv
// Frame pacer with windowed timing statistics.
// One input beat per frame event (action, work_ms, frame_ms) on a valid/ready
// channel; one result beat per event on the output channel, in order.
// A configuration write of frame_rate or measure_enable goes through the APB
// port; the user must issue it only while no event is in flight, which the
// block itself does not enforce; pready is always high.
// An event that records a frame passes FETCH, DECODE, RECORD, INDEX and EMIT;
// one that records nothing skips RECORD. FETCH follows EMIT, so the next event
// is accepted only once EMIT has passed.
// An event that closes a window runs four divisions on the shared bit-serial
// divider of width DIV_W = max(TIME_BITS + log2(MAX_WINDOW), 18), 24 by
// default, between RECORD and INDEX.
// After reset and after every frame_rate write a clearing pass walks the
// window store one entry a cycle, zeroing entries beyond the window length
// (every entry after reset) and summing the rest, while in_ready is low.
// The result sits in an output register: while the receiver stalls the next
// event is still accepted and processed, then held until the slot frees.
`timescale 1ns / 1ps

module frame_pacing_statistics_core #(
  parameter int MAX_WINDOW = 256,
  parameter int TIME_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] work_ms,
  input  logic [15:0] frame_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  sleep_ms,
  output logic        window_done,
  output logic [15:0] avg_frame_ms,
  output logic [15:0] avg_work_ms,
  output logic [17:0] frame_fps_q8,
  output logic [17:0] work_fps_q8,
  output logic [15:0] min_frame_ms,
  output logic [15:0] max_frame_ms
);

  localparam int RATE_W   = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W    = (RATE_W > 9) ? RATE_W : 9;
  localparam int RATE_RST = (60 > MAX_WINDOW) ? MAX_WINDOW : 60;

  logic [RATE_W-1:0] rate;
  logic [RATE_W-1:0] rate_new;
  logic [CMP_W-1:0]  rate_ext;
  logic              measure_en;
  logic              cfg_wr;
  logic              rate_wr;
  fps_pkg::dp_ctrl_t ctrl;
  fps_pkg::dp_stat_t stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign rate_wr = cfg_wr && (paddr[2] == fps_pkg::REG_FRAME_RATE);

  // only pwdata[8:0] is used; zero acts as one, values above the store depth saturate
  always_comb begin
    rate_ext = CMP_W'(pwdata[8:0]);
    if (rate_ext == '0) begin
      rate_new = RATE_W'(1);
    end else if (rate_ext > CMP_W'(MAX_WINDOW)) begin
      rate_new = RATE_W'(MAX_WINDOW);
    end else begin
      rate_new = RATE_W'(rate_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate       <= RATE_W'(RATE_RST);
      measure_en <= 1'b1;
    end else if (cfg_wr) begin
      if (paddr[2] == fps_pkg::REG_FRAME_RATE) begin
        rate <= rate_new;
      end else begin
        measure_en <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == fps_pkg::REG_MEASURE) ? {31'd0, measure_en} : 32'(rate);

  fps_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .restart (rate_wr),
    .in_valid(in_valid),
    .stat    (stat),
    .in_ready(in_ready),
    .ctrl    (ctrl)
  );

  fps_dp #(
    .MAX_WINDOW(MAX_WINDOW),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .stat        (stat),
    .rate_wr     (rate_wr),
    .rate_new    (rate_new),
    .rate        (rate),
    .measure_en  (measure_en),
    .action      (action),
    .work_ms     (work_ms),
    .frame_ms    (frame_ms),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .sleep_ms    (sleep_ms),
    .window_done (window_done),
    .avg_frame_ms(avg_frame_ms),
    .avg_work_ms (avg_work_ms),
    .frame_fps_q8(frame_fps_q8),
    .work_fps_q8 (work_fps_q8),
    .min_frame_ms(min_frame_ms),
    .max_frame_ms(max_frame_ms)
  );

endmodule
